FILE: rtl/dpc_pkg.sv
// ----------------------------------------------------------------------------
// dpc_pkg
// Shared types, constants and helpers of the depth back-projection pipeline.
// ----------------------------------------------------------------------------
package dpc_pkg;

    // depth grid size, pixels outside it give an invalid point
    localparam int GRID_COLUMNS = 1920;
    localparam int GRID_ROWS    = 1080;

    localparam int DEPTH_W = 16;
    localparam int PIX_W   = 12;
    localparam int OFS_W   = 16;   // pixel offset magnitude, Q12.4
    localparam int INV_W   = 24;   // reciprocal focal length, Q0.24
    localparam int CTR_W   = 16;
    localparam int FLIP_W  = 3;
    localparam int CFG_W   = 24;
    localparam int IDX_W   = 3;
    localparam int COORD_W = 24;   // Q8.16 result

    localparam int P1_W  = OFS_W + INV_W;       // offset * reciprocal
    localparam int P2_W  = P1_W + DEPTH_W;      // ... * depth
    localparam int SUM_W = P2_W + 1;
    localparam int Q_W   = 30;                  // quotient input of the /125 unit
    localparam int QS_W  = SUM_W - 15;          // after the /2^15 part of /4096000

    // x/y rounding: (p + 4096000/2) / 4096000 = ((p + 2048000) >> 15) / 125
    localparam logic [SUM_W-1:0] XY_HALF = SUM_W'(2048000);
    // a shifted value at or above this would give a magnitude above 2^23
    localparam logic [QS_W-1:0]  SAT_Q   = QS_W'(1048576125);

    // floor(q/125) = (q * ceil(2^37/125)) >> 37, exact for q below 2^30
    localparam int RECIP_SHIFT = 37;
    localparam int RECIP_W     = 31;
    localparam int PROD_W      = Q_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_125 = RECIP_W'(1099511628);

    // z = (depth*65536 + 500)/1000 = (depth*8192 + 62)/125
    localparam logic [12:0] Z_LOW = 13'd62;

    localparam logic [COORD_W-1:0] POS_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] NEG_MAG = {1'b1, {(COORD_W-1){1'b0}}};

    typedef logic [IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_INV_FOCAL_X = 3'd0;
    localparam cfg_idx_t REG_INV_FOCAL_Y = 3'd1;
    localparam cfg_idx_t REG_CENTER_X    = 3'd2;
    localparam cfg_idx_t REG_CENTER_Y    = 3'd3;
    localparam cfg_idx_t REG_NEAR_LIMIT  = 3'd4;
    localparam cfg_idx_t REG_FAR_LIMIT   = 3'd5;
    localparam cfg_idx_t REG_FLIP_MASK   = 3'd6;

    // per-item control bits carried alongside the data
    typedef struct packed {
        logic pix_ok;
        logic neg_x;
        logic neg_y;
        logic neg_z;
    } pt_ctl_t;

    // magnitude and sign to a saturated two's complement coordinate
    function automatic logic [COORD_W-1:0] pack_axis(input logic [COORD_W-1:0] mag,
                                                     input logic sat,
                                                     input logic neg);
        logic [COORD_W-1:0] res;
        if (neg)
        begin
            if (sat || mag > NEG_MAG)
                res = NEG_MAG;
            else
                res = ~mag + COORD_W'(1);
        end
        else
        begin
            if (sat || mag > POS_MAX)
                res = POS_MAX;
            else
                res = mag;
        end
        return res;
    endfunction

endpackage

FILE: rtl/dpc_front.sv
// ----------------------------------------------------------------------------
// dpc_front
// First stage: pixel qualification, centered offsets and sign selection.
// ----------------------------------------------------------------------------
module dpc_front (
    input  logic                       clk,
    input  logic                       en,
    input  logic [dpc_pkg::DEPTH_W-1:0] depth_mm,
    input  logic                       depth_finite,
    input  logic [dpc_pkg::PIX_W-1:0]  column,
    input  logic [dpc_pkg::PIX_W-1:0]  row,
    input  logic [dpc_pkg::CTR_W-1:0]  center_x,
    input  logic [dpc_pkg::CTR_W-1:0]  center_y,
    input  logic [dpc_pkg::DEPTH_W-1:0] near_limit,
    input  logic [dpc_pkg::DEPTH_W-1:0] far_limit,
    input  logic [dpc_pkg::FLIP_W-1:0] flip_mask,
    output dpc_pkg::pt_ctl_t           ctl_reg,
    output logic [dpc_pkg::OFS_W-1:0]  dx_reg,
    output logic [dpc_pkg::OFS_W-1:0]  dy_reg,
    output logic [dpc_pkg::DEPTH_W-1:0] depth_reg,
    output logic [dpc_pkg::Q_W-1:0]    zq_reg
);
    import dpc_pkg::*;

    logic [OFS_W-1:0] pos_x;
    logic [OFS_W-1:0] pos_y;
    logic             lt_x;
    logic             lt_y;
    logic             in_grid;
    pt_ctl_t          ctl_next;

    // pixel center in Q12.4
    assign pos_x = {column, 4'b1000};
    assign pos_y = {row, 4'b1000};
    assign lt_x  = pos_x < center_x;
    assign lt_y  = pos_y < center_y;

    assign in_grid = ({1'b0, column} < (PIX_W+1)'(GRID_COLUMNS))
                  && ({1'b0, row} < (PIX_W+1)'(GRID_ROWS));

    always_comb
    begin
        ctl_next.pix_ok = depth_finite && (depth_mm > near_limit)
                       && (depth_mm < far_limit) && in_grid;
        ctl_next.neg_x  = lt_x ^ flip_mask[0];
        // y is positive up, so the default sign is flipped
        ctl_next.neg_y  = lt_y ^ ~flip_mask[1];
        ctl_next.neg_z  = flip_mask[2];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl_reg   <= ctl_next;
            dx_reg    <= lt_x ? (center_x - pos_x) : (pos_x - center_x);
            dy_reg    <= lt_y ? (center_y - pos_y) : (pos_y - center_y);
            depth_reg <= depth_mm;
            zq_reg    <= Q_W'({depth_mm, Z_LOW});
        end
    end

endmodule

FILE: rtl/dpc_scale.sv
// ----------------------------------------------------------------------------
// dpc_scale
// Lateral axis scaling: offset * reciprocal focal, * depth, rounding prescale.
// ----------------------------------------------------------------------------
module dpc_scale (
    input  logic                        clk,
    input  logic                        en2,
    input  logic                        en3,
    input  logic                        en4,
    input  logic [dpc_pkg::OFS_W-1:0]   ofs,
    input  logic [dpc_pkg::INV_W-1:0]   inv_focal,
    input  logic [dpc_pkg::DEPTH_W-1:0] depth,
    output logic [dpc_pkg::Q_W-1:0]     q_reg,
    output logic                        sat_reg
);
    import dpc_pkg::*;

    logic [P1_W-1:0]    p1_reg;
    logic [DEPTH_W-1:0] depth2_reg;
    logic [P2_W-1:0]    p2_reg;
    logic [SUM_W-1:0]   sum;
    logic [QS_W-1:0]    qs;

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            p1_reg     <= P1_W'(ofs) * P1_W'(inv_focal);
            depth2_reg <= depth;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3)
            p2_reg <= P2_W'(p1_reg) * P2_W'(depth2_reg);
    end

    assign sum = SUM_W'(p2_reg) + XY_HALF;
    assign qs  = sum[SUM_W-1:15];

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            q_reg   <= qs[Q_W-1:0];
            sat_reg <= qs >= SAT_Q;
        end
    end

endmodule

FILE: rtl/dpc_div125.sv
// ----------------------------------------------------------------------------
// dpc_div125
// Registered division by 125 through a reciprocal multiply.
// ----------------------------------------------------------------------------
module dpc_div125 (
    input  logic                          clk,
    input  logic                          en,
    input  logic [dpc_pkg::Q_W-1:0]       q,
    output logic [dpc_pkg::COORD_W-1:0]   mag
);
    import dpc_pkg::*;

    logic [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
            prod_reg <= PROD_W'(q) * PROD_W'(RECIP_125);
    end

    assign mag = prod_reg[RECIP_SHIFT +: COORD_W];

endmodule

FILE: rtl/dpc_pack.sv
// ----------------------------------------------------------------------------
// dpc_pack
// Output stage: sign, saturation and zeroing of invalid points.
// ----------------------------------------------------------------------------
module dpc_pack (
    input  logic                        clk,
    input  logic                        en,
    input  dpc_pkg::pt_ctl_t            ctl,
    input  logic [dpc_pkg::COORD_W-1:0] mag_x,
    input  logic                        sat_x,
    input  logic [dpc_pkg::COORD_W-1:0] mag_y,
    input  logic                        sat_y,
    input  logic [dpc_pkg::COORD_W-1:0] mag_z,
    output logic [dpc_pkg::COORD_W-1:0] point_x_reg,
    output logic [dpc_pkg::COORD_W-1:0] point_y_reg,
    output logic [dpc_pkg::COORD_W-1:0] point_z_reg,
    output logic                        point_valid_reg
);
    import dpc_pkg::*;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            point_valid_reg <= ctl.pix_ok;
            if (ctl.pix_ok)
            begin
                point_x_reg <= pack_axis(mag_x, sat_x, ctl.neg_x);
                point_y_reg <= pack_axis(mag_y, sat_y, ctl.neg_y);
                point_z_reg <= pack_axis(mag_z, 1'b0, ctl.neg_z);
            end
            else
            begin
                point_x_reg <= '0;
                point_y_reg <= '0;
                point_z_reg <= '0;
            end
        end
    end

endmodule

FILE: rtl/depth_to_point_cloud.sv
// ----------------------------------------------------------------------------
// depth_to_point_cloud
// Pinhole back-projection of depth pixels into Q8.16 metre points.
// ----------------------------------------------------------------------------
// Takes one depth pixel per clock while the pipeline is not backed up and
// returns one point per pixel, in order. The six register stages are the
// pixel qualification, the offset by reciprocal-focal multiply, the multiply
// by depth, the rounding prescale, the reciprocal multiply that divides by 125
// and the sign/saturate output register. Every stage holds its item while the
// stage after it is full and stalled, and empty stages keep filling, so input
// is still taken while a finished point waits at the output until all six
// stages are occupied. Configuration registers must be written by the user
// only when no item is in flight; the block itself does not enforce this.
module depth_to_point_cloud (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [39:0]                 s_tdata,   // depth_mm, column, row
    input  logic                        s_tuser,   // depth_finite
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [71:0]                 m_tdata,   // point_x, point_y, point_z
    output logic                        m_tuser,   // point_valid
    input  logic                        cfg_we,
    input  logic [dpc_pkg::IDX_W-1:0]   cfg_index,
    input  logic [dpc_pkg::CFG_W-1:0]   cfg_data
);
    import dpc_pkg::*;

    localparam int NSTG = 6;

    logic [INV_W-1:0]   inv_focal_x_reg;
    logic [INV_W-1:0]   inv_focal_y_reg;
    logic [CTR_W-1:0]   center_x_reg;
    logic [CTR_W-1:0]   center_y_reg;
    logic [DEPTH_W-1:0] near_limit_reg;
    logic [DEPTH_W-1:0] far_limit_reg;
    logic [FLIP_W-1:0]  flip_mask_reg;

    logic [NSTG:1]      vld_reg;
    logic [NSTG:1]      vld_next;
    logic [NSTG+1:1]    en;

    pt_ctl_t            ctl1;
    pt_ctl_t            ctl2_reg;
    pt_ctl_t            ctl3_reg;
    pt_ctl_t            ctl4_reg;
    pt_ctl_t            ctl5_reg;
    logic [OFS_W-1:0]   dx1;
    logic [OFS_W-1:0]   dy1;
    logic [DEPTH_W-1:0] depth1;
    logic [Q_W-1:0]     zq1;
    logic [Q_W-1:0]     zq2_reg;
    logic [Q_W-1:0]     zq3_reg;
    logic [Q_W-1:0]     zq4_reg;
    logic [Q_W-1:0]     qx4;
    logic [Q_W-1:0]     qy4;
    logic               satx4;
    logic               saty4;
    logic               satx5_reg;
    logic               saty5_reg;
    logic [COORD_W-1:0] magx5;
    logic [COORD_W-1:0] magy5;
    logic [COORD_W-1:0] magz5;
    logic [COORD_W-1:0] point_x;
    logic [COORD_W-1:0] point_y;
    logic [COORD_W-1:0] point_z;
    logic               point_valid;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_focal_x_reg <= INV_W'(9586);
            inv_focal_y_reg <= INV_W'(9586);
            center_x_reg    <= CTR_W'(15360);
            center_y_reg    <= CTR_W'(8640);
            near_limit_reg  <= '0;
            far_limit_reg   <= '1;
            flip_mask_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_INV_FOCAL_X: inv_focal_x_reg <= cfg_data[INV_W-1:0];
                REG_INV_FOCAL_Y: inv_focal_y_reg <= cfg_data[INV_W-1:0];
                REG_CENTER_X:    center_x_reg    <= cfg_data[CTR_W-1:0];
                REG_CENTER_Y:    center_y_reg    <= cfg_data[CTR_W-1:0];
                REG_NEAR_LIMIT:  near_limit_reg  <= cfg_data[DEPTH_W-1:0];
                REG_FAR_LIMIT:   far_limit_reg   <= cfg_data[DEPTH_W-1:0];
                REG_FLIP_MASK:   flip_mask_reg   <= cfg_data[FLIP_W-1:0];
                default:         ;
            endcase
        end
    end

    // a stage loads when it is empty or the stage after it moves on
    always_comb
    begin
        en[NSTG+1] = m_tready;
        for (int k = NSTG; k >= 1; k--)
            en[k] = !vld_reg[k] || en[k+1];
        vld_next[1] = s_tvalid;
        for (int k = 2; k <= NSTG; k++)
            vld_next[k] = vld_reg[k-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            for (int k = 1; k <= NSTG; k++)
                if (en[k])
                    vld_reg[k] <= vld_next[k];
        end
    end

    assign s_tready = en[1];

    dpc_front u_front (
        .clk          (clk),
        .en           (en[1]),
        .depth_mm     (s_tdata[15:0]),
        .depth_finite (s_tuser),
        .column       (s_tdata[27:16]),
        .row          (s_tdata[39:28]),
        .center_x     (center_x_reg),
        .center_y     (center_y_reg),
        .near_limit   (near_limit_reg),
        .far_limit    (far_limit_reg),
        .flip_mask    (flip_mask_reg),
        .ctl_reg      (ctl1),
        .dx_reg       (dx1),
        .dy_reg       (dy1),
        .depth_reg    (depth1),
        .zq_reg       (zq1)
    );

    dpc_scale u_scale_x (
        .clk       (clk),
        .en2       (en[2]),
        .en3       (en[3]),
        .en4       (en[4]),
        .ofs       (dx1),
        .inv_focal (inv_focal_x_reg),
        .depth     (depth1),
        .q_reg     (qx4),
        .sat_reg   (satx4)
    );

    dpc_scale u_scale_y (
        .clk       (clk),
        .en2       (en[2]),
        .en3       (en[3]),
        .en4       (en[4]),
        .ofs       (dy1),
        .inv_focal (inv_focal_y_reg),
        .depth     (depth1),
        .q_reg     (qy4),
        .sat_reg   (saty4)
    );

    // control and z operand follow the lateral stages
    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            ctl2_reg <= ctl1;
            zq2_reg  <= zq1;
        end
        if (en[3])
        begin
            ctl3_reg <= ctl2_reg;
            zq3_reg  <= zq2_reg;
        end
        if (en[4])
        begin
            ctl4_reg <= ctl3_reg;
            zq4_reg  <= zq3_reg;
        end
        if (en[5])
        begin
            ctl5_reg  <= ctl4_reg;
            satx5_reg <= satx4;
            saty5_reg <= saty4;
        end
    end

    dpc_div125 u_div_x (
        .clk (clk),
        .en  (en[5]),
        .q   (qx4),
        .mag (magx5)
    );

    dpc_div125 u_div_y (
        .clk (clk),
        .en  (en[5]),
        .q   (qy4),
        .mag (magy5)
    );

    dpc_div125 u_div_z (
        .clk (clk),
        .en  (en[5]),
        .q   (zq4_reg),
        .mag (magz5)
    );

    dpc_pack u_pack (
        .clk             (clk),
        .en              (en[6]),
        .ctl             (ctl5_reg),
        .mag_x           (magx5),
        .sat_x           (satx5_reg),
        .mag_y           (magy5),
        .sat_y           (saty5_reg),
        .mag_z           (magz5),
        .point_x_reg     (point_x),
        .point_y_reg     (point_y),
        .point_z_reg     (point_z),
        .point_valid_reg (point_valid)
    );

    assign m_tvalid = vld_reg[NSTG];
    assign m_tdata  = {point_z, point_y, point_x};
    assign m_tuser  = point_valid;

    // rejected pixels come out as all zeros
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("invalid point with nonzero coordinates");

    // input only backs up when every stage is full and the output is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (&vld_reg) && !m_tready)
        else $error("input stalled with room in the pipeline");

    // an accepted depth is at least 1 mm, so z of a valid point is never zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[71:48] != '0)
        else $error("valid point with zero z");

endmodule

FILE: verif/dpc_point_checker.sv
// ----------------------------------------------------------------------------
// dpc_point_checker
// Watches the pixel, point and register ports of depth_to_point_cloud, works
// out the point that each accepted pixel must give and compares the points
// leaving the block, in order, against those predictions.
// ----------------------------------------------------------------------------
module dpc_point_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic [39:0]               s_tdata,    // depth_mm, column, row
    input  logic                      s_tuser,    // depth_finite
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic [71:0]               m_tdata,    // point_x, point_y, point_z
    input  logic                      m_tuser,    // point_valid
    input  logic                      cfg_we,
    input  dpc_pkg::cfg_idx_t         cfg_index,
    input  logic [dpc_pkg::CFG_W-1:0] cfg_data,
    output int                        fail_count,
    output int                        points_due,
    output int                        pixels_seen,
    output int                        valid_points
);
    timeunit 1ns;
    timeprecision 1ps;

    import dpc_pkg::*;

    localparam longint unsigned LATERAL_DIV = 64'd4096000;

    typedef struct packed {
        logic               ok;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
    } point_t;

    // register copies
    logic [INV_W-1:0]   inv_fx;
    logic [INV_W-1:0]   inv_fy;
    logic [CTR_W-1:0]   ctr_x;
    logic [CTR_W-1:0]   ctr_y;
    logic [DEPTH_W-1:0] near_mm;
    logic [DEPTH_W-1:0] far_mm;
    logic [FLIP_W-1:0]  flips;

    point_t points_ahead[$];

    // magnitude and sign to a saturated 24-bit two's complement field
    function automatic logic [COORD_W-1:0] to_coord(input longint unsigned mag,
                                                    input logic neg);
        longint unsigned lim;
        lim = mag;
        if (neg)
        begin
            if (lim > 64'd8388608)
                lim = 64'd8388608;
            return COORD_W'(64'd16777216 - lim);
        end
        if (lim > 64'd8388607)
            lim = 64'd8388607;
        return COORD_W'(lim);
    endfunction

    // pixel offset from the center (Q12.4) times reciprocal focal times depth
    function automatic logic [COORD_W-1:0] lateral_offset(input logic [PIX_W-1:0] pix,
                                                          input logic [CTR_W-1:0] ctr,
                                                          input logic [INV_W-1:0] inv,
                                                          input logic [DEPTH_W-1:0] depth,
                                                          input logic negate);
        longint unsigned pos;
        longint unsigned span;
        longint unsigned mag;
        logic            below;
        pos   = 64'(pix) * 64'd16 + 64'd8;
        below = pos < 64'(ctr);
        span  = below ? 64'(ctr) - pos : pos - 64'(ctr);
        // round half away from zero on the magnitude
        mag   = (span * 64'(inv) * 64'(depth) + LATERAL_DIV / 2) / LATERAL_DIV;
        if (mag == 0)
            return '0;
        return to_coord(mag, below ^ negate);
    endfunction

    function automatic point_t project(input logic [DEPTH_W-1:0] depth,
                                       input logic finite,
                                       input logic [PIX_W-1:0] col,
                                       input logic [PIX_W-1:0] row);
        point_t          pt;
        longint unsigned zmag;
        pt = '0;
        if (!finite || depth <= near_mm || depth >= far_mm
            || col >= GRID_COLUMNS || row >= GRID_ROWS)
            return pt;
        pt.ok = 1'b1;
        pt.x  = lateral_offset(col, ctr_x, inv_fx, depth, flips[0]);
        // y points up, so it is negated unless bit1 flips it back
        pt.y  = lateral_offset(row, ctr_y, inv_fy, depth, !flips[1]);
        zmag  = (64'(depth) * 64'd65536 + 64'd500) / 64'd1000;
        pt.z  = (zmag == 0) ? '0 : to_coord(zmag, flips[2]);
        return pt;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        point_t want;
        point_t seen;
        if (!rst_n)
        begin
            inv_fx       = 24'd9586;
            inv_fy       = 24'd9586;
            ctr_x        = 16'd15360;
            ctr_y        = 16'd8640;
            near_mm      = 16'd0;
            far_mm       = 16'd65535;
            flips        = 3'd0;
            points_ahead.delete();
            fail_count   = 0;
            points_due   = 0;
            pixels_seen  = 0;
            valid_points = 0;
        end
        else
        begin
            // retire the outgoing point before queuing a new pixel
            if (m_tvalid && m_tready)
            begin
                seen.ok = m_tuser;
                seen.x  = m_tdata[23:0];
                seen.y  = m_tdata[47:24];
                seen.z  = m_tdata[71:48];
                if (points_ahead.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: point with no pixel: x=%0d y=%0d z=%0d valid=%0b",
                                 $time, $signed(seen.x), $signed(seen.y),
                                 $signed(seen.z), seen.ok);
                end
                else
                begin
                    want = points_ahead.pop_front();
                    if (seen.ok)
                        valid_points++;
                    if (seen !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("%0t: point mismatch", $time);
                            $display("  expected x=%0d y=%0d z=%0d valid=%0b",
                                     $signed(want.x), $signed(want.y),
                                     $signed(want.z), want.ok);
                            $display("  actual   x=%0d y=%0d z=%0d valid=%0b",
                                     $signed(seen.x), $signed(seen.y),
                                     $signed(seen.z), seen.ok);
                        end
                    end
                end
            end

            if (s_tvalid && s_tready)
            begin
                points_ahead.push_back(project(s_tdata[15:0], s_tuser,
                                               s_tdata[27:16], s_tdata[39:28]));
                pixels_seen++;
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_INV_FOCAL_X: inv_fx  = cfg_data[INV_W-1:0];
                    REG_INV_FOCAL_Y: inv_fy  = cfg_data[INV_W-1:0];
                    REG_CENTER_X:    ctr_x   = cfg_data[CTR_W-1:0];
                    REG_CENTER_Y:    ctr_y   = cfg_data[CTR_W-1:0];
                    REG_NEAR_LIMIT:  near_mm = cfg_data[DEPTH_W-1:0];
                    REG_FAR_LIMIT:   far_mm  = cfg_data[DEPTH_W-1:0];
                    REG_FLIP_MASK:   flips   = cfg_data[FLIP_W-1:0];
                    default: ;
                endcase
            end
            points_due = points_ahead.size();
        end
    end

endmodule

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Regression bench for the depth back-projection pipeline.
// ----------------------------------------------------------------------------
// Feeds depth pixels under a series of register settings (reset values, tie
// rounding, saturating reciprocals, zero reciprocals, empty depth windows,
// centered optics and random setups) with random gaps and output stalls, one
// long output hold-off that backs the pipeline up, and an idle drain before
// every register update. A checker beside the block predicts each point.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dpc_pkg::*;

    localparam cfg_idx_t REG_SPARE      = 3'd7;   // no register behind it
    localparam int       WATCHDOG_LIMIT = 4000;
    localparam int       HOLD_OFF       = 300;
    localparam int       TAIL_CYCLES    = 12;
    localparam int       PHASES         = 8;
    localparam int       PHASE_PIXELS   = 54;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [39:0]        s_tdata   = '0;   // depth_mm, column, row
    logic               s_tuser   = 1'b0; // depth_finite
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [71:0]        m_tdata;          // point_x, point_y, point_z
    logic               m_tuser;          // point_valid
    logic               cfg_we    = 1'b0;
    cfg_idx_t           cfg_index = REG_INV_FOCAL_X;
    logic [CFG_W-1:0]   cfg_data  = '0;

    int fail_count;
    int points_due;
    int pixels_seen;
    int valid_points;

    // register values the stimulus currently runs under
    logic [INV_W-1:0]   inv_x   = 24'd9586;
    logic [INV_W-1:0]   inv_y   = 24'd9586;
    logic [CTR_W-1:0]   ctr_x   = 16'd15360;
    logic [CTR_W-1:0]   ctr_y   = 16'd8640;
    logic [DEPTH_W-1:0] near_mm = 16'd0;
    logic [DEPTH_W-1:0] far_mm  = 16'd65535;
    logic [FLIP_W-1:0]  flip    = 3'd0;

    int settings_used = 1;
    int hold_req      = 0;
    int idle_cycles   = 0;
    bit no_idle       = 1'b0;
    bit steady_send   = 1'b0;

    always #10 clk = ~clk;

    depth_to_point_cloud DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    dpc_point_checker point_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .points_due   (points_due),
        .pixels_seen  (pixels_seen),
        .valid_points (valid_points)
    );

    // mostly back to back, sometimes a few cycles, rarely a long pause
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 85)
            return $urandom_range(1, 2);
        if (r < 97)
            return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_pixel(input logic [DEPTH_W-1:0] depth, input logic finite,
                              input logic [PIX_W-1:0] col, input logic [PIX_W-1:0] row);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {row, col, depth};
        s_tuser  <= finite;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        gap = (no_idle || steady_send) ? 0 : gap_len();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_random_pixel();
        logic [DEPTH_W-1:0] depth;
        logic [PIX_W-1:0]   col;
        logic [PIX_W-1:0]   row;
        logic               finite;
        int                 r;
        r      = $urandom_range(0, 99);
        finite = ($urandom_range(0, 99) < 92);
        if (far_mm > near_mm + 1 && r < 8)
            depth = near_mm + 16'd1;
        else if (far_mm > near_mm + 1 && r < 16)
            depth = far_mm - 16'd1;
        else if (far_mm > near_mm + 1 && r < 88)
            depth = 16'($urandom_range(near_mm + 1, far_mm - 1));
        else
            depth = 16'($urandom);
        if ($urandom_range(0, 9) != 0)
        begin
            col = 12'($urandom_range(0, GRID_COLUMNS - 1));
            row = 12'($urandom_range(0, GRID_ROWS - 1));
        end
        else
        begin
            col = 12'($urandom);
            row = 12'($urandom);
        end
        send_pixel(depth, finite, col, row);
    endtask

    // stop offering pixels until every point has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (points_due != 0)
            @(posedge clk);
    endtask

    task automatic put_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic load_regs();
        put_reg(REG_INV_FOCAL_X, inv_x);
        put_reg(REG_INV_FOCAL_Y, inv_y);
        put_reg(REG_CENTER_X, CFG_W'(ctr_x));
        put_reg(REG_CENTER_Y, CFG_W'(ctr_y));
        put_reg(REG_NEAR_LIMIT, CFG_W'(near_mm));
        put_reg(REG_FAR_LIMIT, CFG_W'(far_mm));
        put_reg(REG_FLIP_MASK, CFG_W'(flip));
        put_reg(REG_SPARE, CFG_W'($urandom));
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // output side: random stalls, plus a long hold-off on request
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req > 0)
            begin
                stall_left = hold_req;
                hold_req   = 0;
            end
            else if (stall_left == 0 && !no_idle && $urandom_range(0, 99) < 20)
                stall_left = gap_len() + 1;
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int t;
        int p;
        int k;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: window edges, invalid flags, grid edges, center
        send_pixel(16'd0, 1'b1, 12'd100, 12'd100);
        send_pixel(16'd65535, 1'b1, 12'd100, 12'd100);
        send_pixel(16'd1, 1'b1, 12'd0, 12'd0);
        send_pixel(16'd65534, 1'b1, 12'd1919, 12'd1079);
        send_pixel(16'd1500, 1'b0, 12'd200, 12'd300);
        send_pixel(16'd1500, 1'b1, 12'd1920, 12'd10);
        send_pixel(16'd1500, 1'b1, 12'd10, 12'd1080);
        send_pixel(16'd1500, 1'b1, 12'd4095, 12'd4095);
        send_pixel(16'd65535, 1'b0, 12'd4095, 12'd4095);
        send_pixel(16'd3000, 1'b1, 12'd960, 12'd540);
        send_pixel(16'd2000, 1'b1, 12'd959, 12'd539);
        send_pixel(16'd800, 1'b1, 12'd0, 12'd1079);
        send_pixel(16'd12345, 1'b1, 12'd1919, 12'd0);

        // exact half-way rounding on x and y under each axis flip
        for (t = 0; t < 4; t++)
        begin
            drain();
            inv_x   = 24'd2048;
            inv_y   = 24'd2048;
            ctr_x   = 16'd15367;
            ctr_y   = 16'd8647;
            near_mm = 16'd0;
            far_mm  = 16'd65535;
            flip    = (t == 3) ? 3'd7 : 3'(1 << t);
            load_regs();
            send_pixel(16'd1000, 1'b1, 12'd960, 12'd540);
            send_pixel(16'd3000, 1'b1, 12'd961, 12'd541);
        end

        for (p = 0; p < PHASES; p++)
        begin
            drain();
            case (p)
                0:
                begin
                    // largest reciprocals: x saturates negative and y saturates positive
                    inv_x   = 24'hFFFFFF;
                    inv_y   = 24'hFFFFFF;
                    ctr_x   = 16'd0;
                    ctr_y   = 16'd0;
                    near_mm = 16'd0;
                    far_mm  = 16'd65535;
                    flip    = 3'd7;
                end
                1:
                begin
                    // smallest reciprocals, center past every pixel, one-depth window
                    inv_x   = 24'd1;
                    inv_y   = 24'd1;
                    ctr_x   = 16'hFFFF;
                    ctr_y   = 16'hFFFF;
                    near_mm = 16'd65533;
                    far_mm  = 16'd65535;
                    flip    = 3'd0;
                end
                2:
                begin
                    inv_x   = 24'd0;
                    inv_y   = 24'd0;
                    ctr_x   = 16'($urandom);
                    ctr_y   = 16'($urandom);
                    near_mm = 16'($urandom_range(0, 2000));
                    far_mm  = 16'($urandom_range(30000, 65535));
                    flip    = 3'd5;
                end
                3:
                begin
                    // no depth lies strictly inside
                    inv_x   = 24'($urandom);
                    inv_y   = 24'($urandom);
                    ctr_x   = 16'($urandom);
                    ctr_y   = 16'($urandom);
                    near_mm = 16'd40000;
                    far_mm  = 16'd40001;
                    flip    = 3'd2;
                end
                4:
                begin
                    // optical center on a pixel center
                    inv_x   = 24'd9586;
                    inv_y   = 24'd9586;
                    ctr_x   = 16'd15368;
                    ctr_y   = 16'd8648;
                    near_mm = 16'd300;
                    far_mm  = 16'd8000;
                    flip    = 3'd3;
                end
                default:
                begin
                    inv_x   = ($urandom_range(0, 3) == 0) ? 24'($urandom_range(1, 16777215))
                                                          : 24'($urandom_range(4000, 20000));
                    inv_y   = ($urandom_range(0, 3) == 0) ? 24'($urandom_range(1, 16777215))
                                                          : 24'($urandom_range(4000, 20000));
                    ctr_x   = 16'($urandom_range(0, 16 * GRID_COLUMNS));
                    ctr_y   = 16'($urandom_range(0, 16 * GRID_ROWS));
                    near_mm = 16'($urandom_range(0, 1000));
                    far_mm  = 16'($urandom_range(3000, 65535));
                    flip    = 3'($urandom_range(0, 7));
                end
            endcase
            load_regs();

            // phase 5 backs the pipeline up, phase 6 runs with no idling at all
            no_idle = (p == 6);
            if (p == 5)
            begin
                hold_req    = HOLD_OFF;
                steady_send = 1'b1;
            end
            for (k = 0; k < PHASE_PIXELS; k++)
            begin
                if (k == 40)
                    steady_send = 1'b0;
                send_random_pixel();
            end
            no_idle = 1'b0;
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("run covered %0d pixels, %0d valid points, under %0d register settings",
                 pixels_seen, valid_points, settings_used);
        $display("  incl. saturation, tie rounding, zero reciprocals, empty window, hold-off");
        if (fail_count == 0 && points_due == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/dpc_pkg.sv
rtl/dpc_front.sv
rtl/dpc_scale.sv
rtl/dpc_div125.sv
rtl/dpc_pack.sv
rtl/depth_to_point_cloud.sv
verif/dpc_point_checker.sv
verif/tb.sv
